FILE: design/pidcis_pkg.sv
// ----------------------------------------------------------------------------
// pidcis_pkg
// Shared widths, register indexes and types of the clamped positional PID core.
// ----------------------------------------------------------------------------
package pidcis_pkg;

    localparam int GAIN_W     = 16;   // signed fixed-point gains
    localparam int LIMIT_W    = 15;   // unsigned clamp magnitudes
    localparam int WINDOW_W   = 16;   // unsigned integration window
    localparam int DRIVE_W    = 16;   // signed drive output
    localparam int SUM_W      = 32;   // integral accumulator
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_I_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_D_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd7;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] ki_gain;
        logic signed [GAIN_W-1:0] kd_gain;
        logic [LIMIT_W-1:0]       p_limit;
        logic [LIMIT_W-1:0]       i_limit;
        logic [LIMIT_W-1:0]       d_limit;
        logic [LIMIT_W-1:0]       out_limit;
        logic [WINDOW_W-1:0]      integrate_window;
    } cfg_t;

endpackage

FILE: design/pid_position_clamped_integral_separation_core.sv
// ----------------------------------------------------------------------------
// pid_position_clamped_integral_separation_core
// Positional PID with per-term clamps and integral separation, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_valid / sample_stall carry setpoint and measured.
//   A transaction completes on a rising edge with valid high and stall low.
//   Drive channel: drive_valid / drive_stall carry the clamped drive value,
//   one result transaction per sample transaction, in order.
//   Configuration: cfg_we writes cfg_data into register cfg_index on the
//   clock edge; write only while no sample is in flight.
// Path: the error is formed into the input register; the three gain
//   products, clamps, accumulator update and output clamp are one
//   combinational pass into the drive register.
// Throughput: one sample per cycle while the drive side does not stall.
// Stall: when drive_stall holds a waiting result, the input register keeps
//   its sample and sample_stall rises only if that register is occupied, so
//   one more transaction is absorbed before back pressure reaches the source.
// Reset: rst_n clears all gains, limits and the window (every drive is 0
//   until configured), the integral sum, the stored previous error, and both
//   valid flags.
// ----------------------------------------------------------------------------
module pid_position_clamped_integral_separation_core
    import pidcis_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
)(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0] measured,

    output logic                           drive_valid,
    input  logic                           drive_stall,
    output logic signed [DRIVE_W-1:0]      drive,

    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    localparam int ERR_W    = SAMPLE_WIDTH + 1;       // setpoint - measured
    localparam int DIFF_W   = ERR_W + 1;              // err - last_error
    localparam int CMP_W    = (ERR_W > WINDOW_W) ? ERR_W : WINDOW_W;
    localparam int ACC_W    = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;
    localparam int P_PROD_W = GAIN_W + ERR_W;
    localparam int I_PROD_W = GAIN_W + SUM_W;
    localparam int D_PROD_W = GAIN_W + DIFF_W;
    localparam int TOTAL_W  = DRIVE_W + 2;            // sum of three terms

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KP_GAIN:   cfg_reg.kp_gain          <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_KI_GAIN:   cfg_reg.ki_gain          <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_KD_GAIN:   cfg_reg.kd_gain          <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_P_LIMIT:   cfg_reg.p_limit          <= cfg_data[LIMIT_W-1:0];
                CFG_I_LIMIT:   cfg_reg.i_limit          <= cfg_data[LIMIT_W-1:0];
                CFG_D_LIMIT:   cfg_reg.d_limit          <= cfg_data[LIMIT_W-1:0];
                CFG_OUT_LIMIT: cfg_reg.out_limit        <= cfg_data[LIMIT_W-1:0];
                CFG_WINDOW:    cfg_reg.integrate_window <= cfg_data[WINDOW_W-1:0];
                default:       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: two-entry pipe, input register then drive register
    // ------------------------------------------------------------------
    logic                    s0_valid_reg;
    logic signed [ERR_W-1:0] s0_err_reg;
    logic                    drive_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic advance;      // drive register may load this cycle
    logic sample_take;  // sample transaction completes
    logic move;         // item leaves the input register, state updates

    assign advance      = !drive_valid_reg || !drive_stall;
    assign sample_stall = s0_valid_reg && !advance;
    assign sample_take  = sample_valid && !sample_stall;
    assign move         = s0_valid_reg && advance;

    logic signed [ERR_W-1:0] err_in;
    assign err_in = ERR_W'(setpoint) - ERR_W'(measured);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            s0_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            s0_err_reg <= err_in;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] last_error_reg;
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [SUM_W-1:0] error_sum_next;

    // integral separation: integrate only while |err| < window
    logic [ERR_W-1:0] err_mag;
    logic             in_window;

    assign err_mag   = s0_err_reg[ERR_W-1] ? ERR_W'(-s0_err_reg) : ERR_W'(s0_err_reg);
    assign in_window = CMP_W'(err_mag) < CMP_W'(cfg_reg.integrate_window);

    // accumulate once, saturating to the 32-bit signed range
    logic signed [ACC_W-1:0]   acc_sum;
    logic [ACC_W-SUM_W:0]      acc_top;
    logic signed [SUM_W-1:0]   sum_sat;

    assign acc_sum = ACC_W'(error_sum_reg) + ACC_W'(s0_err_reg);
    assign acc_top = acc_sum[ACC_W-1:SUM_W-1];

    always_comb
    begin
        if ((&acc_top) || !(|acc_top))
        begin
            sum_sat = acc_sum[SUM_W-1:0];
        end
        else if (acc_sum[ACC_W-1])
        begin
            sum_sat = SUM_MIN;
        end
        else
        begin
            sum_sat = SUM_MAX;
        end
    end

    assign error_sum_next = in_window ? sum_sat : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else if (move)
        begin
            last_error_reg <= s0_err_reg;
            error_sum_reg  <= error_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Terms: exact product, floor shift, symmetric clamp
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0]   err_diff;
    logic signed [P_PROD_W-1:0] p_prod;
    logic signed [I_PROD_W-1:0] i_prod;
    logic signed [D_PROD_W-1:0] d_prod;
    logic signed [P_PROD_W-1:0] p_scaled;
    logic signed [I_PROD_W-1:0] i_scaled;
    logic signed [D_PROD_W-1:0] d_scaled;

    assign err_diff = DIFF_W'(s0_err_reg) - DIFF_W'(last_error_reg);

    assign p_prod = P_PROD_W'(cfg_reg.kp_gain) * P_PROD_W'(s0_err_reg);
    assign i_prod = I_PROD_W'(cfg_reg.ki_gain) * I_PROD_W'(sum_sat);
    assign d_prod = D_PROD_W'(cfg_reg.kd_gain) * D_PROD_W'(err_diff);

    // arithmetic shift rounds toward minus infinity
    assign p_scaled = p_prod >>> GAIN_FRAC_BITS;
    assign i_scaled = i_prod >>> GAIN_FRAC_BITS;
    assign d_scaled = d_prod >>> GAIN_FRAC_BITS;

    logic signed [DRIVE_W-1:0] p_term;
    logic signed [DRIVE_W-1:0] i_clamped;
    logic signed [DRIVE_W-1:0] i_term;
    logic signed [DRIVE_W-1:0] d_term;

    pidcis_clamp #(.WIDTH(P_PROD_W)) u_p_clamp
    (
        .value   (p_scaled),
        .limit   (cfg_reg.p_limit),
        .clamped (p_term)
    );

    pidcis_clamp #(.WIDTH(I_PROD_W)) u_i_clamp
    (
        .value   (i_scaled),
        .limit   (cfg_reg.i_limit),
        .clamped (i_clamped)
    );

    pidcis_clamp #(.WIDTH(D_PROD_W)) u_d_clamp
    (
        .value   (d_scaled),
        .limit   (cfg_reg.d_limit),
        .clamped (d_term)
    );

    // outside the window the I term is dropped along with the sum
    assign i_term = in_window ? i_clamped : '0;

    logic signed [TOTAL_W-1:0] total;
    logic signed [DRIVE_W-1:0] drive_next;

    assign total = TOTAL_W'(p_term) + TOTAL_W'(i_term) + TOTAL_W'(d_term);

    pidcis_clamp #(.WIDTH(TOTAL_W)) u_out_clamp
    (
        .value   (total),
        .limit   (cfg_reg.out_limit),
        .clamped (drive_next)
    );

    // ------------------------------------------------------------------
    // Drive register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            drive_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_stall_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s0_valid_reg |-> !sample_stall
    ) else $error("sample_stall raised with empty input register");

    a_move_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        move |=> drive_valid_reg
    ) else $error("item left input register but drive register is empty");

    a_separation_clears_sum: assert property (
        @(posedge clk) disable iff (!rst_n)
        (move && !in_window) |=> (error_sum_reg == '0)
    ) else $error("integral sum not cleared outside the window");

    // the input register holds data only while its valid flag is set
    a_i_term_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        s0_valid_reg |->
            (i_term <= $signed(TOTAL_W'(cfg_reg.i_limit)))
            && (i_term >= -$signed(TOTAL_W'(cfg_reg.i_limit)))
    ) else $error("I term outside its clamp");

endmodule

FILE: design/pidcis_clamp.sv
// ----------------------------------------------------------------------------
// pidcis_clamp
// Symmetric clamp of a signed value to +/- limit, result as a drive-wide word.
// ----------------------------------------------------------------------------
module pidcis_clamp
    import pidcis_pkg::*;
#(
    parameter int WIDTH = 32
)(
    input  logic signed [WIDTH-1:0]   value,
    input  logic [LIMIT_W-1:0]        limit,
    output logic signed [DRIVE_W-1:0] clamped
);

    logic signed [WIDTH-1:0] lim_pos;
    logic signed [WIDTH-1:0] lim_neg;

    assign lim_pos = $signed(WIDTH'(limit));
    assign lim_neg = -lim_pos;

    // |limit| < 2^15, so every chosen value fits the drive width
    always_comb
    begin
        if (value > lim_pos)
        begin
            clamped = lim_pos[DRIVE_W-1:0];
        end
        else if (value < lim_neg)
        begin
            clamped = lim_neg[DRIVE_W-1:0];
        end
        else
        begin
            clamped = value[DRIVE_W-1:0];
        end
    end

endmodule
